// ===== rtl/core/wbps_pkg.sv =====
package wbps_pkg;

   localparam int MaxPattern  = 16;
   localparam int WindowDepth = MaxPattern - 1;
   localparam int OffsetBits  = 32;
   localparam int LenBits     = $clog2(MaxPattern + 1);
   localparam int PosBits     = $clog2(MaxPattern);
   localparam int CsrIdxBits  = 2;
   localparam int CsrDataBits = 64;

   localparam logic [CsrIdxBits-1:0] CsrPatternLow  = 2'd0;
   localparam logic [CsrIdxBits-1:0] CsrPatternHigh = 2'd1;
   localparam logic [CsrIdxBits-1:0] CsrCareMask    = 2'd2;
   localparam logic [CsrIdxBits-1:0] CsrPatternLen  = 2'd3;

   localparam logic [LenBits-1:0] PatternLenReset = LenBits'(1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } wbps_req_type;

   typedef struct packed {
      logic        window_match;
      logic [31:0] match_start;
      logic [31:0] match_count;
      logic        any_found;
      logic [31:0] latest_start;
      logic        region_done;
   } wbps_rsp_type;

endpackage

// ===== rtl/core/wbps_req_if.sv =====
interface wbps_req_if;
   import wbps_pkg::*;

   logic         valid;
   logic         ready;
   wbps_req_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/core/wbps_rsp_if.sv =====
interface wbps_rsp_if;
   import wbps_pkg::*;

   logic         valid;
   logic         ready;
   wbps_rsp_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// ===== rtl/core/wildcard_byte_pattern_scanner_unit.sv =====
// Channel   Direction  Handshake      Contents
// req_chan  in         valid/ready    one region byte and its end-of-region flag
// rsp_chan  out        valid/ready    match flag, start offsets, count, done flag
// csr_*     in         write enable   signature bytes, care mask, signature length
//
// Every request gives exactly one response, via the input and response registers.
// A request can be accepted every cycle until a stalled response lets the input
// register fill and ready drop; the input and response registers each hold one
// request, so up to two requests are in flight. The signature compare against
// the byte window is a single parallel stage. Reset is synchronous and returns
// all state but the window and data registers to defaults.
module wildcard_byte_pattern_scanner_unit (
   input  logic                                clock,
   input  logic                                reset,
   wbps_req_if.sink                            req_chan,
   wbps_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [wbps_pkg::CsrIdxBits-1:0]     csr_index,
   input  logic [wbps_pkg::CsrDataBits-1:0]    csr_write_data
);
   import wbps_pkg::*;

   // Configuration registers
   logic [63:0]             pattern_low_ff;
   logic [63:0]             pattern_high_ff;
   logic [MaxPattern-1:0]   care_mask_ff;
   logic [LenBits-1:0]      pattern_len_ff;

   // Pipeline registers
   logic                    s1_valid_ff;
   wbps_req_type            s1_data_ff;
   logic                    rsp_valid_ff;
   wbps_rsp_type            rsp_data_ff;
   wbps_rsp_type            rsp_data_in;

   // Region state
   logic [7:0]              window_ff [WindowDepth];
   logic [7:0]              window_in [WindowDepth];
   logic [LenBits-1:0]      fill_ff;
   logic [LenBits-1:0]      fill_in;
   logic [OffsetBits-1:0]   offset_ff;
   logic [OffsetBits-1:0]   offset_in;
   logic [31:0]             hit_total_ff;
   logic [31:0]             hit_total_in;
   logic [31:0]             last_start_ff;
   logic [31:0]             last_start_in;
   logic                    seen_hit_ff;
   logic                    seen_hit_in;

   // Compare logic
   logic                    out_free;
   logic                    advance;
   logic [LenBits-1:0]      len_eff;
   logic [LenBits-1:0]      fill_sat;
   logic [8*MaxPattern-1:0] pattern_all;
   logic [7:0]              win_bytes [MaxPattern];
   logic [PosBits-1:0]      pos_idx [MaxPattern];
   logic [MaxPattern-1:0]   byte_ok;
   logic                    window_match;
   logic [OffsetBits-1:0]   start_offset;
   logic [31:0]             hit_total_next;
   logic [31:0]             last_start_next;
   logic                    seen_hit_next;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         care_mask_ff    <= '0;
         pattern_len_ff  <= PatternLenReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            CsrPatternLow:  pattern_low_ff  <= csr_write_data[63:0];
            CsrPatternHigh: pattern_high_ff <= csr_write_data[63:0];
            CsrCareMask:    care_mask_ff    <= csr_write_data[MaxPattern-1:0];
            CsrPatternLen:  pattern_len_ff  <= csr_write_data[LenBits-1:0];
            default: ;
         endcase
      end
   end

   // Length zero acts as one, anything above the window size as the maximum.
   always_comb begin
      if (pattern_len_ff == '0) begin
         len_eff = LenBits'(1);
      end else if (pattern_len_ff > LenBits'(MaxPattern)) begin
         len_eff = LenBits'(MaxPattern);
      end else begin
         len_eff = pattern_len_ff;
      end
      if (fill_ff >= LenBits'(MaxPattern)) begin
         fill_sat = LenBits'(MaxPattern);
      end else begin
         fill_sat = fill_ff + LenBits'(1);
      end
   end

   assign pattern_all = {pattern_high_ff, pattern_low_ff};

   // Signature byte i lines up with the byte that arrived len-1-i requests
   // ago; entry 0 of the byte list is the current byte.
   always_comb begin
      win_bytes[0] = s1_data_ff.data_byte;
      for (int j = 1; j < MaxPattern; j++) begin
         win_bytes[j] = window_ff[j-1];
      end
      for (int i = 0; i < MaxPattern; i++) begin
         pos_idx[i] = PosBits'(len_eff - LenBits'(1) - LenBits'(i));
         byte_ok[i] = (LenBits'(i) >= len_eff) || !care_mask_ff[i]
                      || (win_bytes[pos_idx[i]] == pattern_all[i*8 +: 8]);
      end
   end

   assign window_match = (fill_sat >= len_eff) && (&byte_ok);
   assign start_offset = offset_ff - OffsetBits'(len_eff - LenBits'(1));

   always_comb begin
      hit_total_next  = hit_total_ff;
      last_start_next = last_start_ff;
      seen_hit_next   = seen_hit_ff;
      if (window_match) begin
         if (hit_total_ff != '1) begin
            hit_total_next = hit_total_ff + 32'd1;
         end
         last_start_next = 32'(start_offset);
         seen_hit_next   = 1'b1;
      end
   end

   always_comb begin
      rsp_data_in.window_match = window_match;
      rsp_data_in.match_start  = window_match ? 32'(start_offset) : 32'd0;
      rsp_data_in.match_count  = hit_total_next;
      rsp_data_in.any_found    = seen_hit_next;
      rsp_data_in.latest_start = last_start_next;
      rsp_data_in.region_done  = s1_data_ff.is_last;
   end

   // The last byte of a region clears the region state; the window bytes
   // need no clearing because the fill count keeps them from being read.
   always_comb begin
      window_in[0] = s1_data_ff.data_byte;
      for (int k = 1; k < WindowDepth; k++) begin
         window_in[k] = window_ff[k-1];
      end
      if (s1_data_ff.is_last) begin
         fill_in       = '0;
         offset_in     = '0;
         hit_total_in  = '0;
         last_start_in = '0;
         seen_hit_in   = 1'b0;
      end else begin
         fill_in       = fill_sat;
         offset_in     = offset_ff + OffsetBits'(1);
         hit_total_in  = hit_total_next;
         last_start_in = last_start_next;
         seen_hit_in   = seen_hit_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         offset_ff     <= '0;
         hit_total_ff  <= '0;
         last_start_ff <= '0;
         seen_hit_ff   <= 1'b0;
      end else if (advance) begin
         fill_ff       <= fill_in;
         offset_ff     <= offset_in;
         hit_total_ff  <= hit_total_in;
         last_start_ff <= last_start_in;
         seen_hit_ff   <= seen_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && !s1_data_ff.is_last) begin
         for (int k = 0; k < WindowDepth; k++) begin
            window_ff[k] <= window_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_data_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && s1_data_ff.is_last |=> fill_ff == '0 && offset_ff == '0 && !seen_hit_ff)
      else $error("region state not cleared after the last byte");

   a_match_sets_latest: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.window_match
      |-> rsp_chan.payload.any_found
          && rsp_chan.payload.latest_start == rsp_chan.payload.match_start)
      else $error("match not reflected in latest start");

   a_count_vs_found: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.payload.match_count != 32'd0)
                         == rsp_chan.payload.any_found)
      else $error("match count disagrees with found flag");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LenBits'(MaxPattern))
      else $error("window fill exceeds the window size");

endmodule
